[rtl/s2y_pkg.sv]
// Shared widths, codes and split-multiply helpers for the S-to-Y converter.
// No dependencies; imported by s_to_y_two_port_convert.
package s2y_pkg;

  localparam int SW        = 24;   // S input field
  localparam int EW        = 25;   // 1 +/- S terms
  localparam int PW        = 50;   // first products, delta, numerators
  localparam int HB        = 25;   // split point of a PW operand
  localparam int WW        = 100;  // full products of PW x PW
  localparam int DW        = 98;   // |delta|^2 and numerator magnitudes
  localparam int AW        = 24;   // reference admittance
  localparam int CW        = 25;   // chunk of a magnitude times admittance
  localparam int NCH       = 4;    // chunks per magnitude
  localparam int NW        = 123;  // dividend 2*adm*|v|
  localparam int DIV_STEPS = 34;   // quotient bits
  localparam int OW        = 32;   // Y output field
  localparam int LANES     = 8;
  localparam int NPROD     = 16;
  localparam int NBIG      = 18;
  localparam int TWO_SHIFT = 19;   // 2.0 in Q5.18 as a shift
  localparam int PIPE_DIV0 = 9;
  localparam int NS        = PIPE_DIV0 + DIV_STEPS + 2;

  localparam logic signed [EW-1:0] ONE_Q18   = 25'sd262144;
  localparam logic [AW-1:0]        ADM_RESET = 24'd335544;
  localparam logic                 REG_ADM   = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [PW-1:0] hh;
    logic signed [PW:0]   hl;
    logic signed [PW:0]   lh;
    logic [PW-1:0]        ll;
  } pp_t;

  // four partial products of a signed PW x PW multiply
  function automatic pp_t pp_mul(input logic signed [PW-1:0] a,
                                 input logic signed [PW-1:0] b);
    pp_t r;
    r.hh = $signed(a[PW-1:HB]) * $signed(b[PW-1:HB]);
    r.hl = $signed(a[PW-1:HB]) * $signed({1'b0, b[HB-1:0]});
    r.lh = $signed({1'b0, a[HB-1:0]}) * $signed(b[PW-1:HB]);
    r.ll = a[HB-1:0] * b[HB-1:0];
    return r;
  endfunction

  function automatic logic signed [WW-1:0] pp_sum(input pp_t p);
    logic signed [WW-1:0] hh;
    logic signed [WW-1:0] mid;
    logic signed [WW-1:0] ll;
    hh  = WW'(p.hh);
    mid = WW'(p.hl) + WW'(p.lh);
    ll  = $signed({{(WW-PW){1'b0}}, p.ll});
    return (hh <<< (2 * HB)) + (mid <<< HB) + ll;
  endfunction

endpackage

[rtl/s_to_y_two_port_convert.sv]
// Two-port S to Y parameter converter, fully pipelined.
// Depends on s2y_pkg.
//
// Usage: one frequency point (S11, S12, S21, S22, complex, Q5.18) enters on
// the in_valid_i/in_ready_o channel; the Y matrix (Q7.24 siemens) and a
// status code leave on out_valid_o/out_ready_i, one result per item, in order.
// Throughput is one item per cycle while the receiver does not stall. The pipeline
// is nine stages of products and sums, a divider setup stage, the restoring
// divider with one quotient bit per stage for 34 bits, and one rounding and
// saturation stage.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles are squeezed out while the receiver stalls;
// in_ready_o falls only when every stage holds an item.
// Status: 0 ok, 1 delta zero (all Y fields zero), 2 some field saturated.
// The APB port holds ref_admittance at address 0 (reset 335544, 1/50 ohm);
// write it only while the pipeline is empty.
// Reset empties the pipeline and restores the register; no clearing pass.
module s_to_y_two_port_convert import s2y_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [SW-1:0]  s11_re_i,
  input  logic signed [SW-1:0]  s11_im_i,
  input  logic signed [SW-1:0]  s12_re_i,
  input  logic signed [SW-1:0]  s12_im_i,
  input  logic signed [SW-1:0]  s21_re_i,
  input  logic signed [SW-1:0]  s21_im_i,
  input  logic signed [SW-1:0]  s22_re_i,
  input  logic signed [SW-1:0]  s22_im_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [OW-1:0]  y11_re_o,
  output logic signed [OW-1:0]  y11_im_o,
  output logic signed [OW-1:0]  y12_re_o,
  output logic signed [OW-1:0]  y12_im_o,
  output logic signed [OW-1:0]  y21_re_o,
  output logic signed [OW-1:0]  y21_im_o,
  output logic signed [OW-1:0]  y22_re_o,
  output logic signed [OW-1:0]  y22_im_o,
  output logic [1:0]            status_o
);

  // operand order in stage 1: d1r d1i d2r d2i e1r e1i e2r e2i s12r s12i s21r s21i
  localparam int PA [NPROD] = '{8, 9, 8, 9, 0, 1, 0, 1, 2, 3, 2, 3, 0, 1, 0, 1};
  localparam int PB [NPROD] = '{10, 11, 11, 10, 2, 3, 3, 2, 4, 5, 5, 4, 6, 7, 7, 6};
  localparam logic [DIV_STEPS-1:0] MAG_POS = {{(DIV_STEPS-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic [DIV_STEPS-1:0] MAG_NEG = MAG_POS + 1'b1;

  // ---------------- configuration ----------------
  logic [AW-1:0] adm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adm_q <= ADM_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ADM)) begin
      adm_q <= pwdata[AW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ADM) ? {{(32-AW){1'b0}}, adm_q} : '0;

  // ---------------- stage valid and advance ----------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  // ---------------- datapath ----------------
  logic signed [EW-1:0] a1_d [12];
  logic signed [EW-1:0] a1_q [12];
  logic signed [PW-1:0] p2_d [NPROD];
  logic signed [PW-1:0] p2_q [NPROD];
  logic signed [EW-1:0] s2_q [4];
  logic signed [PW-1:0] pr3, pi3;
  logic signed [PW-1:0] r3_d [10];
  logic signed [PW-1:0] r3_q [10];
  pp_t                  pp4_d [NBIG];
  pp_t                  pp4_q [NBIG];
  logic                 z4_q, z5_q, z6_q, z7_q, z8_q, z9_q;
  logic signed [WW-1:0] b5_q [NBIG];
  logic signed [WW-1:0] den_sum;
  logic [DW-1:0]        den6_q, den7_q, den8_q, den9_q;
  logic signed [WW-1:0] v6_d [LANES];
  logic signed [WW-1:0] v6_q [LANES];
  logic signed [WW-1:0] vabs [LANES];
  logic [DW-1:0]        mag7_q [LANES];
  logic [LANES-1:0]     neg7_q, neg8_q, neg9_q;
  logic [CW*NCH-1:0]    magx [LANES];
  logic [CW+AW-1:0]     pt8_d [LANES][NCH];
  logic [CW+AW-1:0]     pt8_q [LANES][NCH];
  logic [NW-1:0]        nsum [LANES];
  logic [NW-1:0]        n9_q [LANES];

  // divider: index 0 is the setup stage, 1..DIV_STEPS one quotient bit each
  logic [DW-1:0]        dv_rem_d [DIV_STEPS+1][LANES];
  logic [DW-1:0]        dv_rem_q [DIV_STEPS+1][LANES];
  logic [DIV_STEPS-1:0] dv_q_d   [DIV_STEPS+1][LANES];
  logic [DIV_STEPS-1:0] dv_q_q   [DIV_STEPS+1][LANES];
  logic [DIV_STEPS-1:0] dv_nl_d  [DIV_STEPS+1][LANES];
  logic [DIV_STEPS-1:0] dv_nl_q  [DIV_STEPS+1][LANES];
  logic [LANES-1:0]     dv_ovf_d [DIV_STEPS+1];
  logic [LANES-1:0]     dv_ovf_q [DIV_STEPS+1];
  logic [LANES-1:0]     dv_neg_q [DIV_STEPS+1];
  logic [DW-1:0]        dv_den_q [DIV_STEPS+1];
  logic [DIV_STEPS:0]   dv_z_q;
  logic [DW:0]          trial [DIV_STEPS+1][LANES];

  logic [DIV_STEPS:0]   qp [LANES];
  logic [DIV_STEPS-1:0] mag_o [LANES];
  logic [LANES-1:0]     lane_sat;
  logic signed [OW-1:0] y_d [LANES];
  logic signed [OW-1:0] y_q [LANES];
  status_e              st_d, st_q;

  always_comb begin
    // stage 1: 1 +/- S terms
    a1_d[0]  = ONE_Q18 + EW'(s11_re_i);
    a1_d[1]  = EW'(s11_im_i);
    a1_d[2]  = ONE_Q18 + EW'(s22_re_i);
    a1_d[3]  = EW'(s22_im_i);
    a1_d[4]  = ONE_Q18 - EW'(s11_re_i);
    a1_d[5]  = -EW'(s11_im_i);
    a1_d[6]  = ONE_Q18 - EW'(s22_re_i);
    a1_d[7]  = -EW'(s22_im_i);
    a1_d[8]  = EW'(s12_re_i);
    a1_d[9]  = EW'(s12_im_i);
    a1_d[10] = EW'(s21_re_i);
    a1_d[11] = EW'(s21_im_i);

    // stage 2: small products
    for (int i = 0; i < NPROD; i++) begin
      p2_d[i] = a1_q[PA[i]] * a1_q[PB[i]];
    end

    // stage 3: delta and the four numerators
    pr3      = p2_q[0] - p2_q[1];
    pi3      = p2_q[2] + p2_q[3];
    r3_d[0]  = p2_q[4] - p2_q[5] - pr3;
    r3_d[1]  = p2_q[6] + p2_q[7] - pi3;
    r3_d[2]  = p2_q[8] - p2_q[9] + pr3;
    r3_d[3]  = p2_q[10] + p2_q[11] + pi3;
    r3_d[4]  = -(PW'(s2_q[0]) <<< TWO_SHIFT);
    r3_d[5]  = -(PW'(s2_q[1]) <<< TWO_SHIFT);
    r3_d[6]  = -(PW'(s2_q[2]) <<< TWO_SHIFT);
    r3_d[7]  = -(PW'(s2_q[3]) <<< TWO_SHIFT);
    r3_d[8]  = p2_q[12] - p2_q[13] + pr3;
    r3_d[9]  = p2_q[14] + p2_q[15] + pi3;

    // stage 4: partial products for n * conj(delta) and |delta|^2
    pp4_d[0] = pp_mul(r3_q[0], r3_q[0]);
    pp4_d[1] = pp_mul(r3_q[1], r3_q[1]);
    for (int k = 0; k < LANES / 2; k++) begin
      pp4_d[2+4*k] = pp_mul(r3_q[2+2*k], r3_q[0]);
      pp4_d[3+4*k] = pp_mul(r3_q[3+2*k], r3_q[1]);
      pp4_d[4+4*k] = pp_mul(r3_q[3+2*k], r3_q[0]);
      pp4_d[5+4*k] = pp_mul(r3_q[2+2*k], r3_q[1]);
    end

    // stage 6: denominator and real/imag numerators
    den_sum = b5_q[0] + b5_q[1];
    for (int k = 0; k < LANES / 2; k++) begin
      v6_d[2*k]   = b5_q[2+4*k] + b5_q[3+4*k];
      v6_d[2*k+1] = b5_q[4+4*k] - b5_q[5+4*k];
    end

    for (int l = 0; l < LANES; l++) begin
      // stage 7: sign and magnitude
      vabs[l] = v6_q[l][WW-1] ? -v6_q[l] : v6_q[l];
      // stage 8: magnitude times admittance in chunks
      magx[l] = {{(CW*NCH-DW){1'b0}}, mag7_q[l]};
      for (int j = 0; j < NCH; j++) begin
        pt8_d[l][j] = magx[l][CW*j +: CW] * adm_q;
      end
      // stage 9: dividend, doubled for rounding
      nsum[l] = '0;
      for (int j = 0; j < NCH; j++) begin
        nsum[l] = nsum[l] + (NW'(pt8_q[l][j]) << (CW * j));
      end
      // divider setup: a top part not below den means the quotient overflows
      dv_rem_d[0][l]  = DW'(n9_q[l][NW-1:DIV_STEPS]);
      dv_ovf_d[0][l]  = DW'(n9_q[l][NW-1:DIV_STEPS]) >= den9_q;
      dv_q_d[0][l]    = '0;
      dv_nl_d[0][l]   = n9_q[l][DIV_STEPS-1:0];
      trial[0][l]     = '0;
    end

    // divider steps
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[s][l] = {dv_rem_q[s-1][l], dv_nl_q[s-1][l][DIV_STEPS-1]}
                      - {1'b0, dv_den_q[s-1]};
        if (!trial[s][l][DW]) begin
          dv_rem_d[s][l] = trial[s][l][DW-1:0];
        end else begin
          dv_rem_d[s][l] = {dv_rem_q[s-1][l][DW-2:0], dv_nl_q[s-1][l][DIV_STEPS-1]};
        end
        dv_q_d[s][l]  = {dv_q_q[s-1][l][DIV_STEPS-2:0], !trial[s][l][DW]};
        dv_nl_d[s][l] = {dv_nl_q[s-1][l][DIV_STEPS-2:0], 1'b0};
      end
      dv_ovf_d[s] = dv_ovf_q[s-1];
    end

    // output: round half away from zero, saturate
    for (int l = 0; l < LANES; l++) begin
      qp[l]    = {1'b0, dv_q_q[DIV_STEPS][l]} + 1'b1;
      mag_o[l] = qp[l][DIV_STEPS:1];
      lane_sat[l] = dv_ovf_q[DIV_STEPS][l] ||
                    (dv_neg_q[DIV_STEPS][l] ? (mag_o[l] > MAG_NEG) : (mag_o[l] > MAG_POS));
      if (dv_z_q[DIV_STEPS]) begin
        y_d[l] = '0;
      end else if (lane_sat[l]) begin
        y_d[l] = dv_neg_q[DIV_STEPS][l] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
        y_d[l] = dv_neg_q[DIV_STEPS][l] ? -mag_o[l][OW-1:0] : mag_o[l][OW-1:0];
      end
    end
    if (dv_z_q[DIV_STEPS]) begin
      st_d = STAT_ZERO;
    end else if (|lane_sat) begin
      st_d = STAT_SAT;
    end else begin
      st_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a1_q <= a1_d;
    end
    if (en[1]) begin
      p2_q <= p2_d;
      for (int i = 0; i < 4; i++) begin
        s2_q[i] <= a1_q[8+i];
      end
    end
    if (en[2]) begin
      r3_q <= r3_d;
    end
    if (en[3]) begin
      pp4_q <= pp4_d;
      z4_q  <= (r3_q[0] == '0) && (r3_q[1] == '0);
    end
    if (en[4]) begin
      for (int i = 0; i < NBIG; i++) begin
        b5_q[i] <= pp_sum(pp4_q[i]);
      end
      z5_q <= z4_q;
    end
    if (en[5]) begin
      v6_q   <= v6_d;
      den6_q <= den_sum[DW-1:0];
      z6_q   <= z5_q;
    end
    if (en[6]) begin
      for (int l = 0; l < LANES; l++) begin
        mag7_q[l] <= vabs[l][DW-1:0];
        neg7_q[l] <= v6_q[l][WW-1];
      end
      den7_q <= den6_q;
      z7_q   <= z6_q;
    end
    if (en[7]) begin
      pt8_q  <= pt8_d;
      neg8_q <= neg7_q;
      den8_q <= den7_q;
      z8_q   <= z7_q;
    end
    if (en[8]) begin
      for (int l = 0; l < LANES; l++) begin
        n9_q[l] <= {nsum[l][NW-2:0], 1'b0};
      end
      neg9_q <= neg8_q;
      den9_q <= den8_q;
      z9_q   <= z8_q;
    end
    if (en[PIPE_DIV0]) begin
      dv_rem_q[0] <= dv_rem_d[0];
      dv_q_q[0]   <= dv_q_d[0];
      dv_nl_q[0]  <= dv_nl_d[0];
      dv_ovf_q[0] <= dv_ovf_d[0];
      dv_neg_q[0] <= neg9_q;
      dv_den_q[0] <= den9_q;
      dv_z_q[0]   <= z9_q;
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      if (en[PIPE_DIV0+s]) begin
        dv_rem_q[s] <= dv_rem_d[s];
        dv_q_q[s]   <= dv_q_d[s];
        dv_nl_q[s]  <= dv_nl_d[s];
        dv_ovf_q[s] <= dv_ovf_d[s];
        dv_neg_q[s] <= dv_neg_q[s-1];
        dv_den_q[s] <= dv_den_q[s-1];
        dv_z_q[s]   <= dv_z_q[s-1];
      end
    end
    if (en[NS-1]) begin
      y_q  <= y_d;
      st_q <= st_d;
    end
  end

  assign y11_re_o = y_q[0];
  assign y11_im_o = y_q[1];
  assign y12_re_o = y_q[2];
  assign y12_im_o = y_q[3];
  assign y21_re_o = y_q[4];
  assign y21_im_o = y_q[5];
  assign y22_re_o = y_q[6];
  assign y22_im_o = y_q[7];
  assign status_o = st_q;

`ifndef SYNTHESIS
  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_ZERO) |->
      (y11_re_o == '0) && (y12_re_o == '0) && (y21_re_o == '0) && (y22_im_o == '0))
    else $error("delta-zero item with nonzero Y");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item not in first stage");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("ready while every stage is full and output stalled");
`endif

endmodule
